[sv/cor_pkg.sv]
// ----------------------------------------------------------------------------
// cor_pkg
// shared widths, constants and the request and row records of the circle rasterizer
// ----------------------------------------------------------------------------
package cor_pkg;

    localparam int CX_W     = 9;
    localparam int CY_W     = 8;
    localparam int RAD_W    = 7;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 10;
    localparam int SQ_W     = 2 * RAD_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int IN_W     = CX_W + CY_W + RAD_W + COLOR_W;
    localparam int OUT_W    = 8 * COORD_W + COLOR_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;
    localparam int MAX_ROWS = 64;

    // one queued circle request, radius already clamped
    typedef struct packed {
        logic [CX_W-1:0]    cx;
        logic [CY_W-1:0]    cy;
        logic [RAD_W-1:0]   radius;
        logic [SQ_W-1:0]    r2;
        logic [COLOR_W-1:0] color;
    } req_t;

    // one emitted row
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [COORD_W-1:0] row_minus_dx;
        logic [COORD_W-1:0] row_plus_dx;
        logic [COORD_W-1:0] col_minus_dy;
        logic [COORD_W-1:0] col_plus_dy;
        logic [COORD_W-1:0] row_minus_dy;
        logic [COORD_W-1:0] row_plus_dy;
        logic [COORD_W-1:0] col_minus_dx;
        logic [COORD_W-1:0] col_plus_dx;
    } row_t;

endpackage

[sv/cor_front.sv]
// ----------------------------------------------------------------------------
// cor_front
// unpacks a circle request, clamps the radius and forms its square
// ----------------------------------------------------------------------------
module cor_front #(
    parameter int MAX_RADIUS = 80
) (
    input  logic [cor_pkg::IN_W-1:0] s_axis_tdata,
    output cor_pkg::req_t            req
);

    localparam logic [cor_pkg::RAD_W-1:0] RADIUS_CAP = cor_pkg::RAD_W'(MAX_RADIUS);

    logic [cor_pkg::RAD_W-1:0] radius_in;
    logic [cor_pkg::RAD_W-1:0] radius_clamped;

    assign radius_in      = s_axis_tdata[cor_pkg::CX_W+cor_pkg::CY_W +: cor_pkg::RAD_W];
    assign radius_clamped = (radius_in > RADIUS_CAP) ? RADIUS_CAP : radius_in;

    always_comb
    begin
        req.cx     = s_axis_tdata[0 +: cor_pkg::CX_W];
        req.cy     = s_axis_tdata[cor_pkg::CX_W +: cor_pkg::CY_W];
        req.radius = radius_clamped;
        req.r2     = cor_pkg::SQ_W'(radius_clamped) * cor_pkg::SQ_W'(radius_clamped);
        req.color  = s_axis_tdata[cor_pkg::CX_W+cor_pkg::CY_W+cor_pkg::RAD_W +: cor_pkg::COLOR_W];
    end

endmodule

[sv/cor_queue.sv]
// ----------------------------------------------------------------------------
// cor_queue
// two-entry request queue between the front and the row sequencer
// ----------------------------------------------------------------------------
module cor_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cor_pkg::req_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cor_pkg::req_t head
);

    cor_pkg::req_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/cor_back.sv]
// ----------------------------------------------------------------------------
// cor_back
// row sequencer: walks dy upward, steps dx down until dx^2 + dy^2 <= r^2,
// then registers the eight symmetric coordinates of the row
// ----------------------------------------------------------------------------
module cor_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  cor_pkg::req_t               q_head,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cor_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    localparam logic [cor_pkg::RAD_W-1:0] LAST_DY = cor_pkg::RAD_W'(cor_pkg::MAX_ROWS - 1);

    state_t                       state_reg, state_next;
    logic [cor_pkg::CX_W-1:0]     cx_reg, cx_next;
    logic [cor_pkg::CY_W-1:0]     cy_reg, cy_next;
    logic [cor_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic [cor_pkg::SQ_W-1:0]     r2_reg, r2_next;
    logic [cor_pkg::RAD_W-1:0]    dx_reg, dx_next;
    logic [cor_pkg::RAD_W-1:0]    dy_reg, dy_next;
    logic [cor_pkg::SQ_W-1:0]     dx2_reg, dx2_next;
    logic [cor_pkg::SQ_W-1:0]     dy2_reg, dy2_next;
    cor_pkg::row_t                row_reg, row_next;
    logic                         last_reg, last_next;
    logic                         valid_reg, valid_next;

    logic [cor_pkg::SUM_W-1:0]    dist2;
    logic [cor_pkg::COORD_W-1:0]  cx_ext;
    logic [cor_pkg::COORD_W-1:0]  cy_ext;
    logic [cor_pkg::COORD_W-1:0]  dx_ext;
    logic [cor_pkg::COORD_W-1:0]  dy_ext;

    assign dist2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign cx_ext = cor_pkg::COORD_W'(cx_reg);
    assign cy_ext = cor_pkg::COORD_W'(cy_reg);
    assign dx_ext = cor_pkg::COORD_W'(dx_reg);
    assign dy_ext = cor_pkg::COORD_W'(dy_reg);

    assign q_pop         = (state_reg == ST_IDLE) && q_not_empty;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = (cor_pkg::OUT_BYTES*8)'(row_reg);

    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        r2_next    = r2_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        row_next   = row_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    cx_next    = q_head.cx;
                    cy_next    = q_head.cy;
                    color_next = q_head.color;
                    r2_next    = q_head.r2;
                    dx_next    = q_head.radius;
                    dx2_next   = q_head.r2;
                    dy_next    = '0;
                    dy2_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (dist2 > {1'b0, r2_reg})
                begin
                    // (dx-1)^2 = dx^2 - 2dx + 1
                    dx_next  = dx_reg - 1'b1;
                    dx2_next = dx2_reg - cor_pkg::SQ_W'({dx_reg, 1'b0})
                               + cor_pkg::SQ_W'(1);
                end
                else
                begin
                    row_next.col_plus_dx  = cx_ext + dx_ext;
                    row_next.col_minus_dx = cx_ext - dx_ext;
                    row_next.row_plus_dy  = cy_ext + dy_ext;
                    row_next.row_minus_dy = cy_ext - dy_ext;
                    row_next.col_plus_dy  = cx_ext + dy_ext;
                    row_next.col_minus_dy = cx_ext - dy_ext;
                    row_next.row_plus_dx  = cy_ext + dx_ext;
                    row_next.row_minus_dx = cy_ext - dx_ext;
                    row_next.pixel_color  = color_reg;
                    last_next  = !(({1'b0, dy_reg} + 1'b1 < {1'b0, dx_reg})
                                   && (dy_reg < LAST_DY));
                    valid_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // (dy+1)^2 = dy^2 + 2dy + 1
                        dy_next    = dy_reg + 1'b1;
                        dy2_next   = dy2_reg + cor_pkg::SQ_W'({dy_reg, 1'b0})
                                     + cor_pkg::SQ_W'(1);
                        state_next = ST_SEARCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            r2_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            dx2_reg   <= '0;
            dy2_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            r2_reg    <= r2_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dx2_reg   <= dx2_next;
            dy2_reg   <= dy2_next;
            row_reg   <= row_next;
        end
    end

endmodule

[sv/circle_octant_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_top
// circle request in, one item per first-octant row out with eight points
// ----------------------------------------------------------------------------
// first row item: passes the queue entry, the sequencer load and the row register
// per row: the dx search loop in the row sequencer steps dx down one unit at a time,
//   then registers the row and holds it until it is taken
// the request queue holds two circles, so requests are taken while a row waits
// reset: asynchronous, active low; queue empty, sequencer idle, no item valid
module circle_octant_rasterizer_top #(
    parameter int MAX_RADIUS = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // col_center, row_center, radius, color
    input  logic [cor_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // col_plus_dx, col_minus_dx, row_plus_dy, row_minus_dy, col_plus_dy,
    // col_minus_dy, row_plus_dx, row_minus_dx, pixel_color
    output logic [cor_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    // last_row
    output logic                            m_axis_tlast
);

    cor_pkg::req_t req;
    cor_pkg::req_t q_head;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;

    assign s_axis_tready = !q_full;

    cor_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .s_axis_tdata (s_axis_tdata),
        .req          (req)
    );

    cor_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cor_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sv/cor_checker.sv]
// ----------------------------------------------------------------------------
// cor_checker
// port-level checks on the row items of the circle rasterizer
// ----------------------------------------------------------------------------
module cor_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cor_pkg::OUT_BYTES*8-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    cor_pkg::row_t               row;
    logic [cor_pkg::COORD_W-1:0] col_sum_dx;
    logic [cor_pkg::COORD_W-1:0] col_sum_dy;
    logic [cor_pkg::COORD_W-1:0] row_sum_dy;
    logic [cor_pkg::COORD_W-1:0] row_sum_dx;
    logic [cor_pkg::COORD_W-1:0] col_span_dx;
    logic [cor_pkg::COORD_W-1:0] row_span_dx;
    logic [cor_pkg::COORD_W-1:0] col_span_dy;

    assign row         = cor_pkg::row_t'(m_axis_tdata[cor_pkg::OUT_W-1:0]);
    assign col_sum_dx  = row.col_plus_dx + row.col_minus_dx;
    assign col_sum_dy  = row.col_plus_dy + row.col_minus_dy;
    assign row_sum_dy  = row.row_plus_dy + row.row_minus_dy;
    assign row_sum_dx  = row.row_plus_dx + row.row_minus_dx;
    assign col_span_dx = row.col_plus_dx - row.col_minus_dx;
    assign row_span_dx = row.row_plus_dx - row.row_minus_dx;
    assign col_span_dy = row.col_plus_dy - row.col_minus_dy;

    // a stalled row item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("row item changed while stalled");

    // all column points share one center, all row points share one center
    a_center: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (col_sum_dx == col_sum_dy) && (row_sum_dy == row_sum_dx))
        else $error("symmetric points disagree on the center");

    // the same dx spans columns and rows
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> col_span_dx == row_span_dx)
        else $error("dx differs between column and row points");

    // first octant only: dx never below dy
    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> col_span_dx >= col_span_dy)
        else $error("row offset exceeds horizontal offset");

endmodule

bind circle_octant_rasterizer_top cor_checker u_cor_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_circle_octant_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// tb_circle_octant_rasterizer_top
// self-checking bench for the circle octant rasterizer: circle requests go in
// on the slave stream, every emitted row is predicted in the bench and checked
// field by field, with random idling on both streams and a long output stall
// ----------------------------------------------------------------------------
module tb_circle_octant_rasterizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RAD    = 80;
    localparam int RX_HOLD    = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 50;
    localparam int MAX_REPORTS = 200;

    typedef struct {
        cor_pkg::row_t pix;
        logic          last;
    } row_expect_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cor_pkg::IN_W-1:0]        s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cor_pkg::OUT_BYTES*8-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    row_expect_t rows_due[$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_len = 0;
    int          idle_cycles = 0;

    circle_octant_rasterizer_top #(
        .MAX_RADIUS(MAX_RAD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #6 clk = ~clk;

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // rows of the first octant for one circle request
    function automatic void trace_circle(
        input logic [cor_pkg::CX_W-1:0]    cx,
        input logic [cor_pkg::CY_W-1:0]    cy,
        input logic [cor_pkg::RAD_W-1:0]   rad_in,
        input logic [cor_pkg::COLOR_W-1:0] color
    );
        int          r;
        int          dy;
        int          dx;
        int          n;
        bit          more;
        row_expect_t e;
        r = (rad_in > MAX_RAD) ? MAX_RAD : int'(rad_in);
        dy = 0;
        dx = r;
        n = 0;
        do
        begin
            // dx only shrinks as dy grows, so step it down to floor(sqrt)
            while (dx * dx > r * r - dy * dy)
                dx--;
            more = (dy + 1 < dx) && (n + 1 < cor_pkg::MAX_ROWS);
            e.pix.col_plus_dx  = cor_pkg::COORD_W'(int'(cx) + dx);
            e.pix.col_minus_dx = cor_pkg::COORD_W'(int'(cx) - dx);
            e.pix.row_plus_dy  = cor_pkg::COORD_W'(int'(cy) + dy);
            e.pix.row_minus_dy = cor_pkg::COORD_W'(int'(cy) - dy);
            e.pix.col_plus_dy  = cor_pkg::COORD_W'(int'(cx) + dy);
            e.pix.col_minus_dy = cor_pkg::COORD_W'(int'(cx) - dy);
            e.pix.row_plus_dx  = cor_pkg::COORD_W'(int'(cy) + dx);
            e.pix.row_minus_dx = cor_pkg::COORD_W'(int'(cy) - dx);
            e.pix.pixel_color  = color;
            e.last = !more;
            rows_due.push_back(e);
            n++;
            dy++;
        end
        while (more);
    endfunction

    // called right after a rising edge; returns at the edge that takes the item
    task automatic send_circle(
        input logic [cor_pkg::CX_W-1:0]    cx,
        input logic [cor_pkg::CY_W-1:0]    cy,
        input logic [cor_pkg::RAD_W-1:0]   rad,
        input logic [cor_pkg::COLOR_W-1:0] color
    );
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {color, rad, cy, cx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        trace_circle(cx, cy, rad, color);
    endtask

    task automatic random_circle(input int little_pct);
        logic [cor_pkg::CX_W-1:0]  cx;
        logic [cor_pkg::CY_W-1:0]  cy;
        logic [cor_pkg::RAD_W-1:0] rad;
        cx = ($urandom_range(99) < 85) ? cor_pkg::CX_W'($urandom_range(319))
                                       : cor_pkg::CX_W'($urandom);
        cy = ($urandom_range(99) < 85) ? cor_pkg::CY_W'($urandom_range(199))
                                       : cor_pkg::CY_W'($urandom);
        if ($urandom_range(99) < little_pct)
            rad = cor_pkg::RAD_W'($urandom_range(12));
        else if ($urandom_range(99) < 80)
            rad = cor_pkg::RAD_W'($urandom_range(MAX_RAD));
        else
            rad = cor_pkg::RAD_W'($urandom_range(127, MAX_RAD + 1));
        send_circle(cx, cy, rad, cor_pkg::COLOR_W'($urandom));
    endtask

    // sender pauses until every expected row has come out
    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rows_due.size() != 0);
    endtask

    task automatic test_directed();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_circle(9'd160, 8'd100, 7'd0, 8'h00);
        send_circle(9'd160, 8'd100, 7'd1, 8'hff);
        send_circle(9'd160, 8'd100, 7'd2, 8'haa);
        send_circle(9'd160, 8'd100, 7'd5, 8'h55);
        send_circle(9'd160, 8'd100, 7'd80, 8'h01);
        // radius above the limit saturates
        send_circle(9'd160, 8'd100, 7'd81, 8'h80);
        send_circle(9'd160, 8'd100, 7'd127, 8'h7f);
        // coordinates wrap below zero and reach past the input field width
        send_circle(9'd0, 8'd0, 7'd80, 8'h3c);
        send_circle(9'd319, 8'd199, 7'd80, 8'hc3);
        send_circle(9'd511, 8'd255, 7'd127, 8'hff);
        send_circle(9'd0, 8'd255, 7'd5, 8'h00);
        send_circle(9'd511, 8'd0, 7'd5, 8'h12);
        send_circle(9'd10, 8'd10, 7'd50, 8'hed);
        send_circle(9'd319, 8'd0, 7'd3, 8'h0f);
        send_circle(9'd0, 8'd199, 7'd64, 8'hf0);
        send_circle(9'd256, 8'd128, 7'd0, 8'hff);
        drain_rows();
    endtask

    task automatic test_random_traffic(input int n);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        repeat (n) random_circle(20);
        drain_rows();
    endtask

    // output held off while requests keep coming, so the input must stall
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_len = RX_HOLD;
        repeat (8) random_circle(30);
        drain_rows();
    endtask

    task automatic test_streaming(input int n);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (n) random_circle(40);
        drain_rows();
    endtask

    task automatic test_small_circles(input int n);
        tx_idle_pct = 50;
        rx_idle_pct = 50;
        repeat (n) random_circle(85);
        drain_rows();
    endtask

    initial
    begin : rx_side
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap(rx_idle_pct);
            end
        end
    end

    task automatic check_field(
        input string                       name,
        input logic [cor_pkg::COORD_W-1:0] want,
        input logic [cor_pkg::COORD_W-1:0] got
    );
        if (got !== want)
        begin
            // cap the report so a broken block cannot flood the log
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_rows
        cor_pkg::row_t got;
        row_expect_t   want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[cor_pkg::OUT_W-1:0];
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = rows_due.pop_front();
                check_field("col_plus_dx", want.pix.col_plus_dx, got.col_plus_dx);
                check_field("col_minus_dx", want.pix.col_minus_dx, got.col_minus_dx);
                check_field("row_plus_dy", want.pix.row_plus_dy, got.row_plus_dy);
                check_field("row_minus_dy", want.pix.row_minus_dy, got.row_minus_dy);
                check_field("col_plus_dy", want.pix.col_plus_dy, got.col_plus_dy);
                check_field("col_minus_dy", want.pix.col_minus_dy, got.col_minus_dy);
                check_field("row_plus_dx", want.pix.row_plus_dx, got.row_plus_dx);
                check_field("row_minus_dx", want.pix.row_minus_dx, got.row_minus_dx);
                check_field("pixel_color", cor_pkg::COORD_W'(want.pix.pixel_color),
                            cor_pkg::COORD_W'(got.pixel_color));
                check_field("last_row", cor_pkg::COORD_W'(want.last),
                            cor_pkg::COORD_W'(m_axis_tlast));
            end
        end
    end

    // no item moving on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d rows outstanding",
                         $time, IDLE_LIMIT, rows_due.size());
                $display("FAIL circle_octant_rasterizer_top");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(110);
        test_backpressure();
        test_streaming(40);
        test_small_circles(90);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && rows_due.size() == 0)
            $display("PASS circle_octant_rasterizer_top");
        else
            $display("FAIL circle_octant_rasterizer_top");
        $finish;
    end

endmodule

[circle_octant_rasterizer_top.f]
sv/cor_pkg.sv
sv/cor_front.sv
sv/cor_queue.sv
sv/cor_back.sv
sv/circle_octant_rasterizer_top.sv
sv/cor_checker.sv
tb/tb_circle_octant_rasterizer_top.sv
